FILE: sv/ecmv_pkg.sv
// ----------------------------------------------------------------------------
// ecmv_pkg: shared constants and types for the multiturn encoder block
// Field widths, register indexes and the velocity unit handshake structs.
// ----------------------------------------------------------------------------
package ecmv_pkg;

    localparam int COUNT_BITS = 14;
    localparam int TIME_BITS  = 32;
    localparam int TURN_BITS  = 32;
    localparam int ANGLE_BITS = 48;
    localparam int VEL_BITS   = 40;
    localparam int THR_BITS   = 14;
    localparam int FB_BITS    = 20;

    localparam int S_DATA_BITS = 48;
    localparam int M_DATA_BITS = 120;

    // Velocity unit: serial multiply by 1e6, then restoring divide
    localparam int MUL_BITS  = 20;
    localparam int MAG_BITS  = ANGLE_BITS;
    localparam int PROD_BITS = MAG_BITS + MUL_BITS;
    localparam int QUO_BITS  = VEL_BITS;
    localparam int HI_BITS   = PROD_BITS - QUO_BITS;
    localparam int CNT_BITS  = 6;

    localparam logic [MUL_BITS-1:0] US_PER_S = 20'd1000000;

    localparam logic [VEL_BITS-1:0] VEL_POS_MAX = {1'b0, {(VEL_BITS-1){1'b1}}};
    localparam logic [VEL_BITS-1:0] VEL_NEG_MAG = {1'b1, {(VEL_BITS-1){1'b0}}};

    localparam logic [1:0] CFG_WRAP_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_MAX_INTERVAL   = 2'd1;
    localparam logic [1:0] CFG_FALLBACK       = 2'd2;

    typedef struct packed {
        logic                 start;
        logic                 neg;
        logic [MAG_BITS-1:0]  mag;
        logic [TIME_BITS-1:0] dt;
    } vel_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } vel_stat_t;

endpackage

FILE: sv/encoder_multiturn_velocity.sv
// ----------------------------------------------------------------------------
// encoder_multiturn_velocity: multiturn unwrap with velocity estimate
// An accepted item passes the turn update, difference and velocity unit start, then
// 20 serial multiply steps, a range check, 40 divide steps and a finish before the
// result loads; a saturating velocity skips the divide, the first item goes to output.
// A new item waits for that load, which stalls while a result waits on m_tready.
// Reset clears the turn state and loads the register defaults at once.
// ----------------------------------------------------------------------------
module encoder_multiturn_velocity (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [ecmv_pkg::S_DATA_BITS-1:0]     s_tdata,  // raw_count, time_us
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [ecmv_pkg::M_DATA_BITS-1:0]     m_tdata,  // full_angle, turns, velocity
    output logic [0:0]                           m_tuser,  // interval_fixed
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [1:0]                           cfg_index,
    input  logic [31:0]                          cfg_data
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_TURN = 6'b000010,
        ST_DIFF = 6'b000100,
        ST_MAG  = 6'b001000,
        ST_VEL  = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    state_t                                  state_reg, state_next;

    logic [ecmv_pkg::THR_BITS-1:0]           thr_reg;
    logic [ecmv_pkg::TIME_BITS-1:0]          max_reg;
    logic [ecmv_pkg::FB_BITS-1:0]            fb_reg;

    logic [ecmv_pkg::COUNT_BITS-1:0]         raw_reg, raw_next;
    logic [ecmv_pkg::TIME_BITS-1:0]          time_reg, time_next;
    logic [ecmv_pkg::COUNT_BITS-1:0]         prev_raw_reg, prev_raw_next;
    logic [ecmv_pkg::TIME_BITS-1:0]          prev_time_reg, prev_time_next;
    logic [ecmv_pkg::TURN_BITS-1:0]          turn_reg, turn_next;
    logic [ecmv_pkg::ANGLE_BITS-1:0]         prev_full_reg, prev_full_next;
    logic                                    primed_reg, primed_next;
    logic [ecmv_pkg::ANGLE_BITS-1:0]         full_reg, full_next;
    logic [ecmv_pkg::ANGLE_BITS-1:0]         diff_reg, diff_next;
    logic [ecmv_pkg::TIME_BITS-1:0]          dt_reg, dt_next;
    logic                                    fixed_reg, fixed_next;
    logic                                    vel_used_reg, vel_used_next;

    logic                                    m_tvalid_reg, m_tvalid_next;
    logic [ecmv_pkg::M_DATA_BITS-1:0]        m_tdata_reg, m_tdata_next;
    logic                                    m_fixed_reg, m_fixed_next;

    logic signed [ecmv_pkg::COUNT_BITS:0]    jump;
    logic [ecmv_pkg::COUNT_BITS:0]           jump_abs;
    logic [ecmv_pkg::ANGLE_BITS-1:0]         full_c;
    logic                                    fixed_c;
    logic [ecmv_pkg::VEL_BITS-1:0]           vel_u;
    logic [ecmv_pkg::VEL_BITS-1:0]           vel_sel;
    logic                                    load_out;

    ecmv_pkg::vel_req_t                      req;
    ecmv_pkg::vel_stat_t                     stat;

    assign jump     = $signed({1'b0, raw_reg}) - $signed({1'b0, prev_raw_reg});
    assign jump_abs = jump[ecmv_pkg::COUNT_BITS] ? (~jump + 1'b1) : jump;
    assign full_c   = {{(ecmv_pkg::ANGLE_BITS - ecmv_pkg::TURN_BITS - ecmv_pkg::COUNT_BITS)
                         {turn_reg[ecmv_pkg::TURN_BITS-1]}}, turn_reg, raw_reg};
    assign fixed_c  = (dt_reg == '0) || (dt_reg > max_reg);
    assign vel_sel  = vel_used_reg ? vel_u : '0;
    assign load_out = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    assign req.start = (state_reg == ST_MAG);
    assign req.neg   = diff_reg[ecmv_pkg::ANGLE_BITS-1];
    assign req.mag   = diff_reg[ecmv_pkg::ANGLE_BITS-1] ? ('0 - diff_reg) : diff_reg;
    assign req.dt    = dt_reg;

    ecmv_vel u_vel (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .stat  (stat),
        .vel   (vel_u)
    );

    always_comb
    begin
        state_next     = state_reg;
        raw_next       = raw_reg;
        time_next      = time_reg;
        prev_raw_next  = prev_raw_reg;
        prev_time_next = prev_time_reg;
        turn_next      = turn_reg;
        prev_full_next = prev_full_reg;
        primed_next    = primed_reg;
        full_next      = full_reg;
        diff_next      = diff_reg;
        dt_next        = dt_reg;
        fixed_next     = fixed_reg;
        vel_used_next  = vel_used_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    raw_next   = s_tdata[ecmv_pkg::COUNT_BITS-1:0];
                    time_next  = s_tdata[ecmv_pkg::COUNT_BITS +: ecmv_pkg::TIME_BITS];
                    state_next = ST_TURN;
                end
            end
            ST_TURN:
            begin
                prev_raw_next  = raw_reg;
                prev_time_next = time_reg;
                if (!primed_reg)
                begin
                    // initial read: record the sample, no motion yet
                    turn_next      = '0;
                    prev_full_next = '0;
                    primed_next    = 1'b1;
                    full_next      = {{(ecmv_pkg::ANGLE_BITS - ecmv_pkg::COUNT_BITS){1'b0}},
                                      raw_reg};
                    fixed_next     = 1'b0;
                    vel_used_next  = 1'b0;
                    state_next     = ST_OUT;
                end
                else
                begin
                    // a large jump is a wrap: step the turn count against it
                    if (jump_abs > {1'b0, thr_reg})
                    begin
                        turn_next = jump[ecmv_pkg::COUNT_BITS] ? (turn_reg + 1'b1)
                                                              : (turn_reg - 1'b1);
                    end
                    dt_next       = time_reg - prev_time_reg;
                    vel_used_next = 1'b1;
                    state_next    = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                full_next      = full_c;
                diff_next      = full_c - prev_full_reg;
                prev_full_next = full_c;
                fixed_next     = fixed_c;
                if (fixed_c)
                begin
                    dt_next = (fb_reg == '0) ? ecmv_pkg::TIME_BITS'(1)
                            : {{(ecmv_pkg::TIME_BITS - ecmv_pkg::FB_BITS){1'b0}}, fb_reg};
                end
                state_next = ST_MAG;
            end
            ST_MAG:
            begin
                state_next = ST_VEL;
            end
            ST_VEL:
            begin
                if (stat.done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_fixed_next  = m_fixed_reg;
        if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        if (load_out)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {vel_sel, turn_reg, full_reg};
            m_fixed_next  = fixed_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            thr_reg       <= 14'd13107;
            max_reg       <= 32'd500000;
            fb_reg        <= 20'd1000;
            prev_raw_reg  <= '0;
            prev_time_reg <= '0;
            turn_reg      <= '0;
            prev_full_reg <= '0;
            primed_reg    <= 1'b0;
            vel_used_reg  <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prev_raw_reg  <= prev_raw_next;
            prev_time_reg <= prev_time_next;
            turn_reg      <= turn_next;
            prev_full_reg <= prev_full_next;
            primed_reg    <= primed_next;
            vel_used_reg  <= vel_used_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    ecmv_pkg::CFG_WRAP_THRESHOLD: thr_reg <= cfg_data[ecmv_pkg::THR_BITS-1:0];
                    ecmv_pkg::CFG_MAX_INTERVAL:   max_reg <= cfg_data;
                    ecmv_pkg::CFG_FALLBACK:       fb_reg  <= cfg_data[ecmv_pkg::FB_BITS-1:0];
                    default:                      ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        raw_reg     <= raw_next;
        time_reg    <= time_next;
        full_reg    <= full_next;
        diff_reg    <= diff_next;
        dt_reg      <= dt_next;
        fixed_reg   <= fixed_next;
        m_tdata_reg <= m_tdata_next;
        m_fixed_reg <= m_fixed_next;
    end

    assign s_tready   = (state_reg == ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_fixed_reg;

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> (state_reg == ST_VEL))
        else $error("velocity result arrived outside the wait state");

    a_accept_turn: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_TURN))
        else $error("accepted item not taken to the turn update");

    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> m_tvalid)
        else $error("result loaded but not presented");

    a_primed_holds: assert property (@(posedge clk) disable iff (!rst_n)
        primed_reg |=> primed_reg)
        else $error("primed flag dropped without reset");

endmodule

FILE: sv/ecmv_vel.sv
// ----------------------------------------------------------------------------
// ecmv_vel: bit-serial velocity unit
// Magnitude times 1e6 by shift-and-add, one multiplier bit per cycle, then a
// restoring divide by the interval, one quotient bit per cycle, saturated.
// ----------------------------------------------------------------------------
module ecmv_vel (
    input  logic                               clk,
    input  logic                               rst_n,
    input  ecmv_pkg::vel_req_t                 req,
    output ecmv_pkg::vel_stat_t                stat,
    output logic [ecmv_pkg::VEL_BITS-1:0]      vel
);

    typedef enum logic [4:0] {
        U_IDLE = 5'b00001,
        U_MUL  = 5'b00010,
        U_CHK  = 5'b00100,
        U_DIV  = 5'b01000,
        U_FIN  = 5'b10000
    } ustate_t;

    ustate_t                               state_reg, state_next;
    logic [ecmv_pkg::CNT_BITS-1:0]         cnt_reg, cnt_next;
    logic [ecmv_pkg::PROD_BITS-1:0]        acc_reg, acc_next;
    logic [ecmv_pkg::PROD_BITS-1:0]        msh_reg, msh_next;
    logic [ecmv_pkg::QUO_BITS-1:0]         plo_reg, plo_next;
    logic [ecmv_pkg::TIME_BITS-1:0]        rem_reg, rem_next;
    logic [ecmv_pkg::TIME_BITS-1:0]        dt_reg, dt_next;
    logic                                  neg_reg, neg_next;
    logic                                  sat_reg, sat_next;
    logic [ecmv_pkg::VEL_BITS-1:0]         vel_reg, vel_next;
    logic                                  done_c;

    logic [ecmv_pkg::TIME_BITS:0]          trial;
    logic [ecmv_pkg::TIME_BITS:0]          trial_sub;
    logic                                  trial_ge;
    logic [ecmv_pkg::TIME_BITS-1:0]        hi_ext;

    assign trial     = {rem_reg, plo_reg[ecmv_pkg::QUO_BITS-1]};
    assign trial_sub = trial - {1'b0, dt_reg};
    assign trial_ge  = (trial >= {1'b0, dt_reg});
    assign hi_ext    = {{(ecmv_pkg::TIME_BITS-ecmv_pkg::HI_BITS){1'b0}},
                        acc_reg[ecmv_pkg::PROD_BITS-1:ecmv_pkg::QUO_BITS]};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        msh_next   = msh_reg;
        plo_next   = plo_reg;
        rem_next   = rem_reg;
        dt_next    = dt_reg;
        neg_next   = neg_reg;
        sat_next   = sat_reg;
        vel_next   = vel_reg;
        done_c     = 1'b0;
        case (state_reg)
            U_IDLE:
            begin
                if (req.start)
                begin
                    acc_next   = '0;
                    msh_next   = {{ecmv_pkg::MUL_BITS{1'b0}}, req.mag};
                    dt_next    = req.dt;
                    neg_next   = req.neg;
                    cnt_next   = '0;
                    state_next = U_MUL;
                end
            end
            U_MUL:
            begin
                if (ecmv_pkg::US_PER_S[cnt_reg[4:0]])
                begin
                    acc_next = acc_reg + msh_reg;
                end
                msh_next = {msh_reg[ecmv_pkg::PROD_BITS-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ecmv_pkg::CNT_BITS'(ecmv_pkg::MUL_BITS - 1))
                begin
                    state_next = U_CHK;
                end
            end
            U_CHK:
            begin
                // a top part at or above the divisor means a quotient of 2^40 or more
                sat_next = (hi_ext >= dt_reg);
                rem_next = hi_ext;
                plo_next = acc_reg[ecmv_pkg::QUO_BITS-1:0];
                cnt_next = '0;
                state_next = (hi_ext >= dt_reg) ? U_FIN : U_DIV;
            end
            U_DIV:
            begin
                rem_next = trial_ge ? trial_sub[ecmv_pkg::TIME_BITS-1:0]
                                    : trial[ecmv_pkg::TIME_BITS-1:0];
                plo_next = {plo_reg[ecmv_pkg::QUO_BITS-2:0], trial_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ecmv_pkg::CNT_BITS'(ecmv_pkg::QUO_BITS - 1))
                begin
                    state_next = U_FIN;
                end
            end
            U_FIN:
            begin
                if (neg_reg)
                begin
                    vel_next = (sat_reg || plo_reg > ecmv_pkg::VEL_NEG_MAG)
                             ? ecmv_pkg::VEL_NEG_MAG : ('0 - plo_reg);
                end
                else
                begin
                    vel_next = (sat_reg || plo_reg > ecmv_pkg::VEL_POS_MAX)
                             ? ecmv_pkg::VEL_POS_MAX : plo_reg;
                end
                done_c     = 1'b1;
                state_next = U_IDLE;
            end
            default:
            begin
                state_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            cnt_reg   <= '0;
            sat_reg   <= 1'b0;
            neg_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sat_reg   <= sat_next;
            neg_reg   <= neg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        msh_reg <= msh_next;
        plo_reg <= plo_next;
        rem_reg <= rem_next;
        dt_reg  <= dt_next;
        vel_reg <= vel_next;
    end

    assign stat.busy = (state_reg != U_IDLE);
    assign stat.done = done_c;
    assign vel       = vel_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !stat.busy)
        else $error("velocity unit started while busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |=> !stat.busy)
        else $error("velocity unit still busy after done");

    a_rem_below_dt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == U_DIV) |-> (rem_reg < dt_reg))
        else $error("partial remainder not below divisor");

endmodule

FILE: test/encoder_multiturn_velocity_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// encoder_multiturn_velocity_test: self-checking bench for the multiturn unwrap
// Feeds encoder samples with timestamps through the input stream, predicts full
// angle, turn count, velocity and the fallback flag for each item accepted, and
// compares every result item in order. Register settings change between phases
// while the block is idle; both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module encoder_multiturn_velocity_test;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 100;

    typedef struct {
        logic [ecmv_pkg::COUNT_BITS-1:0] raw;
        logic [ecmv_pkg::TIME_BITS-1:0]  stamp;
    } sample_t;

    typedef struct packed {
        logic [ecmv_pkg::ANGLE_BITS-1:0] full_angle;
        logic [ecmv_pkg::TURN_BITS-1:0]  turns;
        logic [ecmv_pkg::VEL_BITS-1:0]   velocity;
        logic                            interval_fixed;
    } angle_rate_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [ecmv_pkg::S_DATA_BITS-1:0] s_tdata = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [ecmv_pkg::M_DATA_BITS-1:0] m_tdata;
    logic [0:0]                       m_tuser;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [1:0]                       cfg_index = ecmv_pkg::CFG_WRAP_THRESHOLD;
    logic [31:0]                      cfg_data = '0;

    sample_t     sample_queue[$];
    angle_rate_t pending_results[$];

    // register copies and unwrap state of the predictor
    logic [ecmv_pkg::THR_BITS-1:0]   cfg_thr = 14'd13107;
    logic [ecmv_pkg::TIME_BITS-1:0]  cfg_max_iv = 32'd500000;
    logic [ecmv_pkg::FB_BITS-1:0]    cfg_fallback = 20'd1000;
    logic                            primed = 1'b0;
    logic [ecmv_pkg::COUNT_BITS-1:0] last_raw = '0;
    logic [ecmv_pkg::TURN_BITS-1:0]  turn_cnt = '0;
    longint                          last_full = 0;
    logic [ecmv_pkg::TIME_BITS-1:0]  last_stamp = '0;

    int          mismatches = 0;
    int          cycles = 0;
    int          hold_off = 0;
    int          rx_stall = 0;
    bit          sample_taken = 1'b0;
    bit          steady = 1'b0;
    int          angle_pos = 0;
    logic [31:0] stamp_gen = '0;

    encoder_multiturn_velocity i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic angle_rate_t unwrap_sample(
        input logic [ecmv_pkg::COUNT_BITS-1:0] raw,
        input logic [ecmv_pkg::TIME_BITS-1:0]  stamp);
        angle_rate_t    res;
        int             step;
        logic [31:0]    dt;
        longint         full;
        longint         diff;
        logic [63:0]    mag;
        logic [127:0]   quo;
        res = '0;
        if (!primed)
        begin
            // initial read: record only
            primed = 1'b1;
            last_raw = raw;
            last_stamp = stamp;
            turn_cnt = '0;
            last_full = 0;
            res.full_angle = {{(ecmv_pkg::ANGLE_BITS-ecmv_pkg::COUNT_BITS){1'b0}}, raw};
            return res;
        end
        step = int'(raw) - int'(last_raw);
        if ((step < 0 ? -step : step) > int'(cfg_thr))
            turn_cnt = (step > 0) ? turn_cnt - 1'b1 : turn_cnt + 1'b1;
        last_raw = raw;
        full = longint'($signed(turn_cnt)) * (64'sd1 <<< ecmv_pkg::COUNT_BITS)
             + longint'(raw);
        dt = stamp - last_stamp;
        if (dt == 0 || dt > cfg_max_iv)
        begin
            dt = (cfg_fallback == 0) ? 32'd1 : {12'd0, cfg_fallback};
            res.interval_fixed = 1'b1;
        end
        diff = full - last_full;
        mag = (diff < 0) ? 64'(-diff) : 64'(diff);
        quo = ({64'd0, mag} * {108'd0, ecmv_pkg::US_PER_S}) / {96'd0, dt};
        if (diff < 0)
        begin
            if (quo > {88'd0, ecmv_pkg::VEL_NEG_MAG})
                quo = {88'd0, ecmv_pkg::VEL_NEG_MAG};
            res.velocity = '0 - quo[ecmv_pkg::VEL_BITS-1:0];
        end
        else
        begin
            if (quo > {88'd0, ecmv_pkg::VEL_POS_MAX})
                quo = {88'd0, ecmv_pkg::VEL_POS_MAX};
            res.velocity = quo[ecmv_pkg::VEL_BITS-1:0];
        end
        res.full_angle = full[ecmv_pkg::ANGLE_BITS-1:0];
        res.turns = turn_cnt;
        last_full = full;
        last_stamp = stamp;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns: mismatch in %s: got %h, expected %h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic add_sample(input logic [ecmv_pkg::COUNT_BITS-1:0] raw,
                              input logic [ecmv_pkg::TIME_BITS-1:0] stamp);
        sample_t smp;
        smp.raw = raw;
        smp.stamp = stamp;
        sample_queue.push_back(smp);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (index)
            ecmv_pkg::CFG_WRAP_THRESHOLD: cfg_thr = value[ecmv_pkg::THR_BITS-1:0];
            ecmv_pkg::CFG_MAX_INTERVAL:   cfg_max_iv = value;
            ecmv_pkg::CFG_FALLBACK:       cfg_fallback = value[ecmv_pkg::FB_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [ecmv_pkg::THR_BITS-1:0] thr,
                              input logic [31:0] max_iv,
                              input logic [ecmv_pkg::FB_BITS-1:0] fallback);
        write_reg(ecmv_pkg::CFG_WRAP_THRESHOLD, {18'd0, thr});
        write_reg(ecmv_pkg::CFG_MAX_INTERVAL, max_iv);
        write_reg(ecmv_pkg::CFG_FALLBACK, {12'd0, fallback});
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // check at the rising edge, where the stream inputs are settled
    task automatic wait_drained;
        do
            @(posedge clk);
        while (sample_queue.size() != 0 || s_tvalid || pending_results.size() != 0);
    endtask

    // shaft motion with random steps and sample intervals, some noise mixed in
    task automatic motion_samples(input int count);
        int          pick;
        logic [31:0] gap;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
                angle_pos += int'($urandom_range(400)) - 200;
            else if (pick < 75)
                angle_pos += int'($urandom_range(6000)) - 3000;
            else if (pick < 85)
                angle_pos += ($urandom_range(1) ? 1 : -1) * int'($urandom_range(16383, 8000));
            else if (pick < 95)
                angle_pos = $urandom;
            pick = $urandom_range(99);
            if (pick < 60)
                gap = $urandom_range(3000, 1);
            else if (pick < 68)
                gap = '0;
            else if (pick < 74)
                gap = cfg_max_iv;
            else if (pick < 80)
                gap = cfg_max_iv + 1;
            else if (pick < 90)
                gap = $urandom;
            else
            begin
                stamp_gen = $urandom;
                gap = '0;
            end
            stamp_gen += gap;
            add_sample(angle_pos[ecmv_pkg::COUNT_BITS-1:0], stamp_gen);
        end
    endtask

    // sender
    always @(negedge clk)
    begin
        if (rst_n && !(s_tvalid && !sample_taken))
        begin
            sample_taken = 1'b0;
            if (hold_off > 0)
            begin
                hold_off--;
                s_tvalid <= 1'b0;
            end
            else if (sample_queue.size() == 0 || (!steady && $urandom_range(99) < 35))
            begin
                s_tvalid <= 1'b0;
                if (!steady && $urandom_range(999) < 5)
                    hold_off = $urandom_range(90, 1);
            end
            else
            begin
                s_tdata <= {2'b00, sample_queue[0].stamp, sample_queue[0].raw};
                s_tvalid <= 1'b1;
                void'(sample_queue.pop_front());
            end
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (rx_stall > 0)
        begin
            rx_stall--;
            m_tready <= 1'b0;
        end
        else if (steady)
            m_tready <= 1'b1;
        else
        begin
            m_tready <= ($urandom_range(99) >= 35);
            if ($urandom_range(999) < 2)
                rx_stall = $urandom_range(90, 1);
        end
    end

    // check results, then predict for the item taken at this edge
    always @(posedge clk)
    begin
        angle_rate_t want;
        if (m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with nothing expected", m_tdata[63:0], '0);
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[ecmv_pkg::ANGLE_BITS-1:0] !== want.full_angle)
                    report_mismatch("full_angle", 64'(m_tdata[ecmv_pkg::ANGLE_BITS-1:0]),
                                    64'(want.full_angle));
                if (m_tdata[ecmv_pkg::ANGLE_BITS +: ecmv_pkg::TURN_BITS] !== want.turns)
                    report_mismatch("turns",
                                    64'(m_tdata[ecmv_pkg::ANGLE_BITS +: ecmv_pkg::TURN_BITS]),
                                    64'(want.turns));
                if (m_tdata[ecmv_pkg::ANGLE_BITS+ecmv_pkg::TURN_BITS +: ecmv_pkg::VEL_BITS]
                    !== want.velocity)
                    report_mismatch("velocity",
                                    64'(m_tdata[ecmv_pkg::ANGLE_BITS+ecmv_pkg::TURN_BITS
                                                +: ecmv_pkg::VEL_BITS]),
                                    64'(want.velocity));
                if (m_tuser[0] !== want.interval_fixed)
                    report_mismatch("interval_fixed", 64'(m_tuser[0]),
                                    64'(want.interval_fixed));
            end
        end
        if (s_tvalid && s_tready)
        begin
            sample_taken = 1'b1;
            pending_results.push_back(unwrap_sample(
                s_tdata[ecmv_pkg::COUNT_BITS-1:0],
                s_tdata[ecmv_pkg::COUNT_BITS +: ecmv_pkg::TIME_BITS]));
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** encoder_multiturn_velocity: FAILED **");
            $finish;
        end
    end

    initial
    begin
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // register defaults: initial read, timestamp wrap, wrap edges
        add_sample(14'h3FFF, 32'hFFFF_FFF0);
        add_sample(14'h0000, 32'h0000_0010);
        add_sample(14'h0000, 32'h0000_0010);
        add_sample(14'h3FFF, 32'h0000_0010 + 32'd500000);
        add_sample(14'h3FFF, 32'h0000_0010 + 32'd1000001);
        add_sample(14'd100, 32'h0000_0010 + 32'd1000002);
        add_sample(14'd13207, 32'h0000_0010 + 32'd1000003);
        add_sample(14'd99, 32'h0000_0010 + 32'd1000010);
        add_sample(14'h2AAA, 32'hAAAA_AAAA);
        add_sample(14'h1555, 32'h5555_5555);
        add_sample(14'h3FFF, 32'hFFFF_FFFF);
        add_sample(14'h0000, 32'h0000_0000);
        wait_drained;

        // zero registers: every change wraps, every interval falls back to one
        set_config(14'd0, 32'd0, 20'd0);
        add_sample(14'd5, 32'd100);
        add_sample(14'd5, 32'd100);
        add_sample(14'd6, 32'd101);
        add_sample(14'd4, 32'd200);
        wait_drained;

        set_config(14'd16383, 32'hFFFF_FFFF, 20'd1000000);
        add_sample(14'd0, 32'd0);
        add_sample(14'd16383, 32'd1);
        add_sample(14'd0, 32'd1);
        add_sample(14'd8000, 32'd0);
        wait_drained;

        set_config(14'd1, 32'd1, 20'd1);
        add_sample(14'd0, 32'd10);
        add_sample(14'd1, 32'd11);
        add_sample(14'd3, 32'd12);
        add_sample(14'd3, 32'd14);
        wait_drained;

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: set_config(14'd8192, 32'd3000, 20'd1);
                1: set_config(14'($urandom_range(16383, 1)), $urandom,
                              20'($urandom_range(1000000, 1)));
                2: set_config(14'd13107, 32'd500000, 20'd1000);
                3: set_config(14'($urandom_range(16383, 1)), $urandom_range(1000000, 1),
                              20'($urandom_range(1000000, 1)));
                4: set_config(14'd200, $urandom_range(2000, 1), 20'($urandom_range(1000000, 1)));
                default: set_config(14'd16000, $urandom, 20'd1000000);
            endcase
            angle_pos = $urandom;
            steady = (ph == 3);
            motion_samples(105);
            wait_drained;
            steady = 1'b0;
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("results never delivered", 64'(pending_results.size()), '0);
        if (mismatches == 0)
            $display("** encoder_multiturn_velocity: PASSED **");
        else
            $display("** encoder_multiturn_velocity: FAILED **");
        $finish;
    end

endmodule
